[rtl/ksc_pkg.sv]
// ----------------------------------------------------------------------------
// Keyword substitution cipher package
// Shared constants, operation codes and the letter decoder.
// ----------------------------------------------------------------------------
package ksc_pkg;

    localparam int unsigned LETTERS = 26;
    localparam int unsigned IDX_W   = $clog2(LETTERS);

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);
    localparam logic [IDX_W-1:0] NUM_LETTERS = IDX_W'(LETTERS);

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_KEY   = 2'd1,
        OP_TEXT  = 2'd2
    } t_op;

    typedef struct packed {
        logic             is_letter;
        logic             is_lower;
        logic [IDX_W-1:0] idx;
    } t_letter;

    // Classify a byte: letter flag, case and alphabet index (zero for non-letters)
    function automatic t_letter letter_decode(input logic [7:0] b);
        t_letter res;
        res = '0;
        if (b >= UPPER_A && b <= UPPER_Z) begin
            res.is_letter = 1'b1;
            res.idx       = IDX_W'(b - UPPER_A);
        end else if (b >= LOWER_A && b <= LOWER_Z) begin
            res.is_letter = 1'b1;
            res.is_lower  = 1'b1;
            res.idx       = IDX_W'(b - LOWER_A);
        end
        return res;
    endfunction

endpackage

[rtl/keyword_substitution_cipher.sv]
// ----------------------------------------------------------------------------
// Keyword substitution cipher
// Builds a cipher alphabet from keyword bytes, completes it with the unused
// letters from Z down to A, and encrypts or decrypts text bytes with it.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                               Transfer
//  s_axis    in         tuser: operation, tdata: data_byte    tvalid & tready
//  m_axis    out        tdata: out_byte                       tvalid & tready
//  cfg       in         i_cfg_data: decrypt_mode              valid & ready
//
//  Clear and keyword transactions complete as they are accepted in S_IDLE.
//  A text transaction passes through accept, table read and result load.
//  The first text byte after a clear or reset first finishes the forward and
//  inverse tables, writing each unused letter, Z down to A, through the RAM write ports.
//  Reset is synchronous and clears the alphabet state; the tables need none.
//  A result held by a stalled m_axis keeps the next text byte in its load step.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher
    import ksc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] operation
    // Output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    // Configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_RD   = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [LETTERS-1:0]   r_used, n_used;
    logic [IDX_W-1:0]     r_count, n_count;
    logic                 r_built, n_built;
    logic [IDX_W-1:0]     r_k, n_k;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [7:0]           r_byte, n_byte;
    logic                 r_lower, n_lower;
    logic                 r_letter, n_letter;
    logic                 r_mode;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_data, n_out_data;

    logic                 fwd_we, inv_we;
    logic [IDX_W-1:0]     fwd_wdata, inv_waddr;
    logic [IDX_W-1:0]     fwd_rdata, inv_rdata;
    logic [IDX_W-1:0]     sub_idx;
    logic                 in_xact;
    t_letter              in_let;

    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign in_let        = letter_decode(s_axis_tdata);
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign sub_idx       = r_mode ? inv_rdata : fwd_rdata;

    // Cipher alphabet and its inverse
    ksc_ram #(.DEPTH(LETTERS), .WIDTH(IDX_W)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (fwd_we),
        .i_waddr (r_count),
        .i_wdata (fwd_wdata),
        .i_raddr (r_idx),
        .o_rdata (fwd_rdata)
    );

    ksc_ram #(.DEPTH(LETTERS), .WIDTH(IDX_W)) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (inv_we),
        .i_waddr (inv_waddr),
        .i_wdata (r_count),
        .i_raddr (r_idx),
        .o_rdata (inv_rdata)
    );

    // Sequence keyword placement, table completion and lookup
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_count     = r_count;
        n_built     = r_built;
        n_k         = r_k;
        n_idx       = r_idx;
        n_byte      = r_byte;
        n_lower     = r_lower;
        n_letter    = r_letter;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        fwd_we      = 1'b0;
        inv_we      = 1'b0;
        fwd_wdata   = r_k;
        inv_waddr   = r_k;

        // Drop the result once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    unique case (s_axis_tuser)
                        OP_CLEAR: begin
                            n_used  = '0;
                            n_count = '0;
                            n_built = 1'b0;
                        end
                        OP_KEY: begin
                            // Append a new letter to the alphabet
                            if (!r_built && in_let.is_letter && !r_used[in_let.idx]) begin
                                fwd_we              = 1'b1;
                                inv_we              = 1'b1;
                                fwd_wdata           = in_let.idx;
                                inv_waddr           = in_let.idx;
                                n_used[in_let.idx]  = 1'b1;
                                n_count             = r_count + 1'b1;
                            end
                        end
                        OP_TEXT: begin
                            n_idx    = in_let.idx;
                            n_byte   = s_axis_tdata;
                            n_lower  = in_let.is_lower;
                            n_letter = in_let.is_letter;
                            n_k      = LAST_IDX;
                            n_state  = r_built ? S_RD : S_FILL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                // Visit the letters Z down to A, placing each unused one
                if (!r_used[r_k]) begin
                    fwd_we        = 1'b1;
                    inv_we        = 1'b1;
                    n_used[r_k]   = 1'b1;
                    n_count       = r_count + 1'b1;
                end
                n_k = r_k - 1'b1;
                if (r_k == '0) begin
                    n_built = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WB;
            end
            S_WB: begin
                // Load the result once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_letter
                                ? (r_lower ? LOWER_A : UPPER_A) + {3'b000, sub_idx}
                                : r_byte;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_count     <= '0;
            r_built     <= 1'b0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_count     <= n_count;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_idx      <= n_idx;
        r_byte     <= n_byte;
        r_lower    <= n_lower;
        r_letter   <= n_letter;
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    // Every placed letter bumps the fill count exactly once
    a_count_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == 32'(r_count))
        else $error("letter count out of step with used letters");

    // A completed alphabet holds all letters
    a_built_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_built |-> (r_count == NUM_LETTERS))
        else $error("table marked complete with missing letters");

    // Completion ends with a full alphabet before the lookup
    a_fill_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) && (r_k == '0) |=> (r_state == S_RD) && (r_count == NUM_LETTERS))
        else $error("table completion left the alphabet short");

    // A pending result blocks the next load
    a_wb_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) && r_out_valid && !m_axis_tready |=> (r_state == S_WB))
        else $error("result loaded over a pending output");
`endif

endmodule

[rtl/ksc_ram.sv]
// ----------------------------------------------------------------------------
// Keyword substitution cipher table RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ksc_ram #(
    parameter  int unsigned DEPTH = 26,
    parameter  int unsigned WIDTH = 5,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[dv/keyword_substitution_cipher_test.sv]
// ----------------------------------------------------------------------------
// Keyword substitution cipher testbench
// Streams clear, keyword and text transactions into the cipher with random
// idle bursts on both sides, predicts every result with a local model of the
// alphabet tables, and checks each output byte in order. Both modes are run.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_test;
    import ksc_pkg::*;

    // Operation code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Cycles that cover a table completion plus the result pipeline
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_STALL    = 300;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
    } t_cipher_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic [1:0] s_axis_tuser = 2'd0;    // [1:0] operation
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data = 1'b0;

    keyword_substitution_cipher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Cipher state mirrored by the predictor
    logic [4:0]  fwd_alphabet [LETTERS];
    logic [4:0]  inv_alphabet [LETTERS];
    logic [25:0] letters_placed = '0;
    logic [4:0]  alphabet_len = '0;
    logic        alphabet_done = 1'b0;
    logic        decrypt_on = 1'b0;

    t_cipher_item pending_items [$];
    logic [7:0]   cipher_bytes_due [$];

    int  mismatches = 0;
    int  items_queued = 0;
    bit  idle_on = 1'b1;
    bit  in_took = 1'b0;
    int  send_gap = 0;
    int  recv_hold = 0;
    int  long_stalls_asked = 0;
    int  long_stalls_done = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Append one cipher letter unless the alphabet is already full
    function automatic void place_cipher_letter(input logic [4:0] idx);
        if (alphabet_len < LETTERS) begin
            fwd_alphabet[alphabet_len] = idx;
            alphabet_len++;
        end
        letters_placed[idx] = 1'b1;
    endfunction

    // Advance the cipher state by one input transaction
    function automatic void predict_cipher(input logic [1:0] op, input logic [7:0] b);
        logic       letter;
        logic       lower;
        logic [4:0] idx;
        logic [4:0] sub;
        letter = 1'b0;
        lower  = 1'b0;
        idx    = '0;
        if (b >= UPPER_A && b <= UPPER_Z) begin
            letter = 1'b1;
            idx    = 5'(b - UPPER_A);
        end else if (b >= LOWER_A && b <= LOWER_Z) begin
            letter = 1'b1;
            lower  = 1'b1;
            idx    = 5'(b - LOWER_A);
        end
        case (op)
            OP_CLEAR: begin
                letters_placed = '0;
                alphabet_len   = '0;
                alphabet_done  = 1'b0;
            end
            OP_KEY: begin
                if (!alphabet_done && letter && !letters_placed[idx])
                    place_cipher_letter(idx);
            end
            OP_TEXT: begin
                // Finish the alphabet from Z down to A, then invert it
                if (!alphabet_done) begin
                    for (int k = LETTERS - 1; k >= 0; k--) begin
                        if (!letters_placed[k])
                            place_cipher_letter(5'(k));
                    end
                    for (int i = 0; i < LETTERS; i++)
                        inv_alphabet[fwd_alphabet[i]] = 5'(i);
                    alphabet_done = 1'b1;
                end
                if (letter) begin
                    sub = decrypt_on ? inv_alphabet[idx] : fwd_alphabet[idx];
                    cipher_bytes_due.push_back((lower ? LOWER_A : UPPER_A) + 8'(sub));
                end else begin
                    cipher_bytes_due.push_back(b);
                end
            end
            default: ;
        endcase
    endfunction

    // Sample accepted transactions, predict, and check results
    always @(posedge i_clk) begin : monitor
        logic [7:0] want;
        in_took = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_took)
            predict_cipher(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            decrypt_on = i_cfg_data;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cipher_bytes_due.size() == 0) begin
                $display("%0t: unexpected out_byte, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = cipher_bytes_due.pop_front();
                if (m_axis_tdata !== want) begin
                    $display("%0t: out_byte mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Feed pending items into the input stream, with random gaps between them
    always @(negedge i_clk) begin : driver
        t_cipher_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_took) begin
            // hold the offered transaction until it is taken
        end else if (send_gap > 0) begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 16);
            s_axis_tvalid <= 1'b0;
        end else begin
            item = pending_items.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= item.op;
            s_axis_tdata  <= item.data;
        end
    end

    // Drive output ready with random stalls and requested long holds
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_stalls_done < long_stalls_asked) begin
            long_stalls_done++;
            recv_hold = LONG_STALL - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            recv_hold = $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void queue_item(input logic [1:0] op, input logic [7:0] data);
        t_cipher_item item;
        item.op   = op;
        item.data = data;
        pending_items.push_back(item);
        if (op != OP_UNUSED)
            items_queued++;
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one message: an optional clear, keyword, then text with a few strays, or a burst of noise
    function automatic void queue_message();
        int key_len;
        int text_len;
        if ($urandom_range(0, 9) == 0) begin
            // noise: arbitrary operations and bytes
            repeat ($urandom_range(1, 5))
                queue_item(2'($urandom_range(0, 3)), rand_byte());
            return;
        end
        if ($urandom_range(0, 7) != 0)
            queue_item(OP_CLEAR, rand_byte());
        key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        repeat (key_len)
            queue_item(OP_KEY, ($urandom_range(0, 9) == 0) ? rand_byte() : rand_letter());
        text_len = $urandom_range(1, 16);
        repeat (text_len) begin
            case ($urandom_range(0, 19))
                0:       queue_item(OP_KEY, rand_letter());
                1:       queue_item(OP_UNUSED, rand_byte());
                2, 3, 4: queue_item(OP_TEXT, rand_byte());
                default: queue_item(OP_TEXT, rand_letter());
            endcase
        end
    endfunction

    task automatic queue_messages(input int count);
        int target;
        target = items_queued + count;
        while (items_queued < target)
            queue_message();
    endtask

    // Wait until every item is taken and every result has come back
    task automatic drain();
        while (pending_items.size() != 0 || s_axis_tvalid || cipher_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Encrypt: empty keyword, non-letter edges, late keyword, short keyword
        write_mode(1'b0);
        queue_item(OP_CLEAR, 8'h00);
        queue_item(OP_TEXT, 8'h41);
        queue_item(OP_TEXT, 8'h7A);
        queue_item(OP_TEXT, 8'h00);
        queue_item(OP_TEXT, 8'hFF);
        queue_item(OP_TEXT, 8'h80);
        queue_item(OP_TEXT, 8'h40);
        queue_item(OP_TEXT, 8'h5B);
        queue_item(OP_TEXT, 8'h60);
        queue_item(OP_TEXT, 8'h7B);
        queue_item(OP_KEY, 8'h51);
        queue_item(OP_TEXT, 8'h51);
        queue_item(OP_UNUSED, 8'hFF);
        queue_item(OP_CLEAR, 8'hFF);
        queue_item(OP_KEY, 8'h5A);
        queue_item(OP_KEY, 8'h65);
        queue_item(OP_KEY, 8'h62);
        queue_item(OP_KEY, 8'h72);
        queue_item(OP_KEY, 8'h61);
        queue_item(OP_KEY, 8'h7A);
        queue_item(OP_KEY, 8'h31);
        queue_item(OP_TEXT, 8'h61);
        queue_item(OP_TEXT, 8'h5A);
        queue_item(OP_TEXT, 8'h6D);
        queue_item(OP_TEXT, 8'h7A);
        drain();

        // Decrypt: a keyword naming every letter, then random messages
        write_mode(1'b1);
        queue_item(OP_CLEAR, 8'h00);
        for (int i = 0; i < LETTERS; i++)
            queue_item(OP_KEY, UPPER_A + 8'((i * 7) % LETTERS));
        queue_item(OP_KEY, 8'h61);
        queue_item(OP_TEXT, 8'h41);
        queue_item(OP_TEXT, 8'h7A);
        queue_messages(120);
        drain();

        // Encrypt under a long output stall so the input backs up
        write_mode(1'b0);
        long_stalls_asked++;
        queue_messages(150);
        drain();

        write_mode(1'b1);
        queue_messages(150);
        drain();

        // Final stretch at full rate
        write_mode(1'b0);
        idle_on = 1'b0;
        queue_messages(150);
        drain();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/ksc_pkg.sv
rtl/ksc_ram.sv
rtl/keyword_substitution_cipher.sv
dv/keyword_substitution_cipher_test.sv
